@@ rtl/mfrc_pkg.sv @@
// ---------------------------------------------------------------------------
// Modbus frame receive check package
// Shared types and constants for the received-frame checker.
// ---------------------------------------------------------------------------
package mfrc_pkg;

    localparam int MAX_FRAME_CHARS = 1023;
    localparam int TCP_HEADER_LEN  = 7;
    localparam int CHAR_COUNT_W    = $clog2(MAX_FRAME_CHARS + 1);
    localparam int QUEUE_DEPTH     = 2;
    localparam int QUEUE_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int PDU_LEN_W       = 9;

    localparam logic [7:0]  ASCII_START = 8'h3A;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'hA001;

    typedef enum logic [1:0] {
        MODE_RTU   = 2'd0,
        MODE_ASCII = 2'd1,
        MODE_TCP   = 2'd2,
        MODE_FAIL  = 2'd3
    } t_frame_mode;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       last_byte;
    } t_rx_beat;

    typedef struct packed {
        logic [7:0]           data_byte;
        logic                 data_valid;
        logic                 frame_done;
        logic                 frame_ok;
        logic [7:0]           node_address;
        logic [PDU_LEN_W-1:0] pdu_length;
    } t_rx_result;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       last_byte;
        logic [3:0] nibble;
        logic       hex_ok;
        logic       is_start;
    } t_char_info;

endpackage

@@ rtl/mfrc_front.sv @@
// ---------------------------------------------------------------------------
// Modbus frame receive check front end
// Classifies each received character: hex digit value, hex validity and
// whether it is the ASCII start character.
// ---------------------------------------------------------------------------
module mfrc_front (
    input  mfrc_pkg::t_rx_beat   i_beat,
    output mfrc_pkg::t_char_info o_info
);

    logic [7:0] c;

    assign c = i_beat.rx_byte;

    always_comb begin
        o_info           = '0;
        o_info.rx_byte   = c;
        o_info.last_byte = i_beat.last_byte;
        o_info.is_start  = (c == mfrc_pkg::ASCII_START);
        if (c >= 8'h30 && c <= 8'h39) begin
            o_info.nibble = c[3:0];
            o_info.hex_ok = 1'b1;
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            o_info.nibble = 4'(c[3:0] + 4'd9);
            o_info.hex_ok = 1'b1;
        end else begin
            o_info.nibble = 4'd0;
            o_info.hex_ok = 1'b0;
        end
    end

endmodule

@@ rtl/mfrc_queue.sv @@
// ---------------------------------------------------------------------------
// Modbus frame receive check queue
// Short queue of classified characters between the front end and the
// checking engine.
// ---------------------------------------------------------------------------
module mfrc_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  mfrc_pkg::t_char_info i_push_data,
    output logic                 o_full,
    input  logic                 i_pop,
    output logic                 o_valid,
    output mfrc_pkg::t_char_info o_data
);

    mfrc_pkg::t_char_info r_mem [mfrc_pkg::QUEUE_DEPTH];

    logic [mfrc_pkg::QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [mfrc_pkg::QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [mfrc_pkg::QUEUE_CNT_W-1:0] r_count;
    logic [mfrc_pkg::QUEUE_CNT_W-1:0] n_count;
    logic                             do_push;
    logic                             do_pop;

    assign o_full  = (r_count == mfrc_pkg::QUEUE_CNT_W'(mfrc_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                if (r_wr_ptr == mfrc_pkg::QUEUE_PTR_W'(mfrc_pkg::QUEUE_DEPTH - 1)) begin
                    r_wr_ptr <= '0;
                end else begin
                    r_wr_ptr <= r_wr_ptr + 1'b1;
                end
            end
            if (do_pop) begin
                if (r_rd_ptr == mfrc_pkg::QUEUE_PTR_W'(mfrc_pkg::QUEUE_DEPTH - 1)) begin
                    r_rd_ptr <= '0;
                end else begin
                    r_rd_ptr <= r_rd_ptr + 1'b1;
                end
            end
        end
    end

endmodule

@@ rtl/mfrc_back.sv @@
// ---------------------------------------------------------------------------
// Modbus frame receive check engine
// Runs the CRC, LRC or TCP check on queued characters, one per cycle while
// the output is not stalled, and holds the result beat in an output register.
// ---------------------------------------------------------------------------
module mfrc_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [1:0]             i_cfg_wr_data,
    input  logic                   i_q_valid,
    input  mfrc_pkg::t_char_info   i_q_data,
    output logic                   o_q_pop,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output mfrc_pkg::t_rx_result   o_out_data
);

    localparam int CW = mfrc_pkg::CHAR_COUNT_W;

    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ mfrc_pkg::CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    mfrc_pkg::t_frame_mode r_mode;

    logic [15:0]   r_crc,        n_crc;
    logic [7:0]    r_lrc,        n_lrc;
    logic [7:0]    r_lrc_before, n_lrc_before;
    logic [3:0]    r_high,       n_high;
    logic          r_high_bad,   n_high_bad;
    logic [CW-1:0] r_count,      n_count;
    logic [7:0]    r_first,      n_first;
    logic          r_bad,        n_bad;
    logic          r_start,      n_start;
    logic [7:0]    r_held,       n_held;
    logic          r_held_valid, n_held_valid;
    logic          r_held_bad,   n_held_bad;
    logic          r_overlong,   n_overlong;

    logic                 r_out_valid;
    mfrc_pkg::t_rx_result r_out;
    mfrc_pkg::t_rx_result res;

    logic [CW-1:0] idx;
    logic [7:0]    b;
    logic [7:0]    pair;
    logic [CW-1:0] summed;
    logic [CW-1:0] len;
    logic          ok;

    assign o_q_pop     = i_q_valid && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_crc        = r_crc;
        n_lrc        = r_lrc;
        n_lrc_before = r_lrc_before;
        n_high       = r_high;
        n_high_bad   = r_high_bad;
        n_count      = r_count;
        n_first      = r_first;
        n_bad        = r_bad;
        n_start      = r_start;
        n_held       = r_held;
        n_held_valid = r_held_valid;
        n_held_bad   = r_held_bad;
        n_overlong   = r_overlong;
        res          = '0;
        idx          = r_count;
        b            = i_q_data.rx_byte;
        pair         = {r_high, i_q_data.nibble};
        summed       = '0;
        len          = '0;
        ok           = 1'b0;

        if (idx >= CW'(mfrc_pkg::MAX_FRAME_CHARS)) begin
            n_overlong = 1'b1;
        end else begin
            case (r_mode)
                mfrc_pkg::MODE_RTU: begin
                    n_crc = crc_update(r_crc, b);
                    if (idx == '0) begin
                        n_first = b;
                    end
                    res.data_byte  = b;
                    res.data_valid = 1'b1;
                end
                mfrc_pkg::MODE_ASCII: begin
                    if (idx == '0) begin
                        n_start = i_q_data.is_start;
                    end else if (idx[0]) begin
                        n_high     = i_q_data.nibble;
                        n_high_bad = !i_q_data.hex_ok;
                    end else begin
                        if (r_held_valid) begin
                            if (r_start) begin
                                res.data_byte  = r_held;
                                res.data_valid = 1'b1;
                            end
                            if (r_held_bad) begin
                                n_bad = 1'b1;
                            end
                        end
                        n_lrc_before = r_lrc;
                        n_lrc        = r_lrc + pair;
                        if (idx == CW'(2)) begin
                            n_first = pair;
                        end
                        n_held       = pair;
                        n_held_bad   = r_high_bad || !i_q_data.hex_ok;
                        n_held_valid = 1'b1;
                    end
                end
                mfrc_pkg::MODE_TCP: begin
                    if (idx == CW'(mfrc_pkg::TCP_HEADER_LEN - 1)) begin
                        n_first = b;
                    end
                    res.data_byte  = b;
                    res.data_valid = 1'b1;
                end
                default: begin
                end
            endcase
            n_count = idx + 1'b1;
        end

        if (i_q_data.last_byte) begin
            res.frame_done = 1'b1;
            summed = (n_count - CW'(3)) >> 1;
            if (!n_overlong && n_count >= CW'(3)) begin
                case (r_mode)
                    mfrc_pkg::MODE_RTU: begin
                        ok  = (n_crc == 16'h0000);
                        len = n_count - CW'(3);
                    end
                    mfrc_pkg::MODE_ASCII: begin
                        ok  = n_start && !n_bad && (summed >= CW'(2)) &&
                              (n_lrc_before == 8'h00);
                        len = summed - CW'(2);
                    end
                    mfrc_pkg::MODE_TCP: begin
                        ok = 1'b1;
                        if (n_count >= CW'(mfrc_pkg::TCP_HEADER_LEN)) begin
                            len = n_count - CW'(mfrc_pkg::TCP_HEADER_LEN);
                        end
                    end
                    default: begin
                        ok = 1'b0;
                    end
                endcase
            end
            if (ok) begin
                res.frame_ok     = 1'b1;
                res.node_address = n_first;
                if (len > CW'({mfrc_pkg::PDU_LEN_W{1'b1}})) begin
                    res.pdu_length = '1;
                end else begin
                    res.pdu_length = len[mfrc_pkg::PDU_LEN_W-1:0];
                end
            end
            n_crc        = mfrc_pkg::CRC_INIT;
            n_lrc        = '0;
            n_lrc_before = '0;
            n_high       = '0;
            n_high_bad   = 1'b0;
            n_count      = '0;
            n_first      = '0;
            n_bad        = 1'b0;
            n_start      = 1'b0;
            n_held       = '0;
            n_held_valid = 1'b0;
            n_held_bad   = 1'b0;
            n_overlong   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_wr_en) begin
            r_crc        <= mfrc_pkg::CRC_INIT;
            r_lrc        <= '0;
            r_lrc_before <= '0;
            r_high       <= '0;
            r_high_bad   <= 1'b0;
            r_count      <= '0;
            r_first      <= '0;
            r_bad        <= 1'b0;
            r_start      <= 1'b0;
            r_held       <= '0;
            r_held_valid <= 1'b0;
            r_held_bad   <= 1'b0;
            r_overlong   <= 1'b0;
        end else if (o_q_pop) begin
            r_crc        <= n_crc;
            r_lrc        <= n_lrc;
            r_lrc_before <= n_lrc_before;
            r_high       <= n_high;
            r_high_bad   <= n_high_bad;
            r_count      <= n_count;
            r_first      <= n_first;
            r_bad        <= n_bad;
            r_start      <= n_start;
            r_held       <= n_held;
            r_held_valid <= n_held_valid;
            r_held_bad   <= n_held_bad;
            r_overlong   <= n_overlong;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= mfrc_pkg::MODE_RTU;
        end else if (i_cfg_wr_en) begin
            r_mode <= mfrc_pkg::t_frame_mode'(i_cfg_wr_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_out <= res;
        end
    end

endmodule

@@ rtl/modbus_frame_receive_check_top.sv @@
// ---------------------------------------------------------------------------
// Modbus frame receive check
// Checks received RTU, ASCII or TCP frames one character per beat and
// reports data bytes and the end-of-frame status.
//
//   Channel   Direction  Handshake                  Payload
//   input     in         i_in_valid / o_in_stall    i_in_data  (t_rx_beat)
//   output    out        o_out_valid / i_out_stall  o_out_data (t_rx_result)
//   config    in         i_cfg_wr_en                i_cfg_wr_data (frame mode)
//
// One character is taken per cycle while the queue is not full. A beat's result
// passes through the queue and then the engine's output register.
// A two-entry queue decouples the input from the engine, so the input is
// stalled only when the queue is full. Reset is synchronous and active low;
// it selects RTU mode and clears the frame state. A mode write also clears it.
// ---------------------------------------------------------------------------
module modbus_frame_receive_check_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  mfrc_pkg::t_rx_beat   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output mfrc_pkg::t_rx_result o_out_data,
    input  logic                 i_cfg_wr_en,
    input  logic [1:0]           i_cfg_wr_data
);

    mfrc_pkg::t_char_info front_info;
    mfrc_pkg::t_char_info q_data;
    logic                 q_full;
    logic                 q_valid;
    logic                 q_pop;

    assign o_in_stall = q_full;

    mfrc_front u_front (
        .i_beat (i_in_data),
        .o_info (front_info)
    );

    mfrc_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_in_valid),
        .i_push_data (front_info),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_valid     (q_valid),
        .o_data      (q_data)
    );

    mfrc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_q_valid     (q_valid),
        .i_q_data      (q_data),
        .o_q_pop       (q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_data    (o_out_data)
    );

endmodule

@@ tb/modbus_frame_receive_check_top_tb.sv @@
// ---------------------------------------------------------------------------
// Modbus frame receive check testbench
// Drives received frames in RTU, ASCII, TCP and failing mode, one character
// per beat, with random gaps on both channels and one long receiver hold-off.
// A directed table comes first, then random phases of well-formed and
// damaged frames. A local model of the frame checker predicts each result
// beat unless a directed row gives its own; each is compared field by field.
// ---------------------------------------------------------------------------
module modbus_frame_receive_check_top_tb;
    import mfrc_pkg::*;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam int HOLD_OFF_CYCLES = 300;

    typedef struct packed {
        t_frame_mode mode;
        t_rx_beat    beat;
        logic        typed;
        t_rx_result  want;
    } dir_row_t;

    localparam t_rx_result NO_RES = '0;

    localparam dir_row_t DIRECTED [23] = '{
        {MODE_RTU,   {8'h00, 1'b0}, 1'b1, {8'h00, 1'b1, 1'b0, 1'b0, 8'h00, 9'd0}},
        {MODE_RTU,   {8'hFF, 1'b1}, 1'b1, {8'hFF, 1'b1, 1'b1, 1'b0, 8'h00, 9'd0}},
        {MODE_RTU,   {8'h01, 1'b0}, 1'b0, NO_RES},
        {MODE_RTU,   {8'h03, 1'b0}, 1'b0, NO_RES},
        {MODE_RTU,   {8'h00, 1'b0}, 1'b0, NO_RES},
        {MODE_RTU,   {8'h00, 1'b0}, 1'b0, NO_RES},
        {MODE_RTU,   {8'h00, 1'b0}, 1'b0, NO_RES},
        {MODE_RTU,   {8'h01, 1'b0}, 1'b0, NO_RES},
        {MODE_RTU,   {8'h84, 1'b0}, 1'b0, NO_RES},
        {MODE_RTU,   {8'h0A, 1'b1}, 1'b0, NO_RES},
        {MODE_ASCII, {8'h3A, 1'b0}, 1'b0, NO_RES},
        {MODE_ASCII, {8'h30, 1'b0}, 1'b0, NO_RES},
        {MODE_ASCII, {8'h31, 1'b0}, 1'b0, NO_RES},
        {MODE_ASCII, {8'h66, 1'b0}, 1'b0, NO_RES},
        {MODE_ASCII, {8'h46, 1'b0}, 1'b0, NO_RES},
        {MODE_ASCII, {8'h0D, 1'b0}, 1'b0, NO_RES},
        {MODE_ASCII, {8'h0A, 1'b1}, 1'b0, NO_RES},
        {MODE_FAIL,  {8'h78, 1'b0}, 1'b1, {8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 9'd0}},
        {MODE_FAIL,  {8'h80, 1'b0}, 1'b1, {8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 9'd0}},
        {MODE_FAIL,  {8'h7A, 1'b1}, 1'b1, {8'h00, 1'b0, 1'b1, 1'b0, 8'h00, 9'd0}},
        {MODE_TCP,   {8'h12, 1'b0}, 1'b1, {8'h12, 1'b1, 1'b0, 1'b0, 8'h00, 9'd0}},
        {MODE_TCP,   {8'h34, 1'b0}, 1'b1, {8'h34, 1'b1, 1'b0, 1'b0, 8'h00, 9'd0}},
        {MODE_TCP,   {8'h56, 1'b1}, 1'b1, {8'h56, 1'b1, 1'b1, 1'b1, 8'h00, 9'd0}}
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    t_rx_beat   in_data = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    t_rx_result out_data;
    logic       cfg_wr_en = 1'b0;
    logic [1:0] cfg_wr_data = 2'd0;

    t_rx_result  pending_results[$];
    logic [7:0]  frame_chars[$];
    int unsigned mismatch_count = 0;
    int unsigned results_seen = 0;
    int unsigned accepted_chars = 0;
    bit          send_idle = 1'b1;
    bit          recv_idle = 1'b1;

    t_frame_mode cur_mode;
    logic [15:0] crc_acc;
    logic [7:0]  lrc_acc;
    logic [7:0]  lrc_prev;
    logic [7:0]  addr_byte;
    logic [7:0]  pair_byte;
    logic [3:0]  hi_nib;
    bit          hi_bad;
    bit          pair_held;
    bit          pair_bad;
    bit          bad_seen;
    bit          saw_colon;
    bit          too_long;
    int unsigned n_chars;

    modbus_frame_receive_check_top i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_in_data     (in_data),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_out_data    (out_data),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    always #5 clk = ~clk;

    function automatic int idle_gap(bit enabled);
        int r;
        if (!enabled) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 30);
    endfunction

    function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic bit hex_nibble(input logic [7:0] c, output logic [3:0] v);
        v = 4'h0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = 4'(c - 8'h30);
            return 1'b1;
        end
        if (c >= 8'h41 && c <= 8'h46) begin
            v = 4'(c - 8'h41 + 8'd10);
            return 1'b1;
        end
        if (c >= 8'h61 && c <= 8'h66) begin
            v = 4'(c - 8'h61 + 8'd10);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [7:0] to_hex_char(logic [3:0] v);
        if (v < 4'd10) begin
            return 8'h30 + 8'(v);
        end
        return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(v) - 8'd10;
    endfunction

    function automatic void clear_frame_state();
        crc_acc   = CRC_INIT;
        lrc_acc   = 8'h00;
        lrc_prev  = 8'h00;
        addr_byte = 8'h00;
        pair_byte = 8'h00;
        hi_nib    = 4'h0;
        hi_bad    = 1'b0;
        pair_held = 1'b0;
        pair_bad  = 1'b0;
        bad_seen  = 1'b0;
        saw_colon = 1'b0;
        too_long  = 1'b0;
        n_chars   = 0;
    endfunction

    function automatic t_rx_result frame_check_step(t_rx_beat b);
        t_rx_result  r;
        logic [3:0]  nib;
        logic [7:0]  pair;
        bit          nib_ok;
        bit          ok;
        int unsigned n;
        int unsigned len;
        int unsigned summed;
        r = '0;
        if (n_chars >= MAX_FRAME_CHARS) begin
            too_long = 1'b1;
        end else begin
            case (cur_mode)
                MODE_RTU: begin
                    crc_acc = crc16_byte(crc_acc, b.rx_byte);
                    if (n_chars == 0) begin
                        addr_byte = b.rx_byte;
                    end
                    r.data_byte  = b.rx_byte;
                    r.data_valid = 1'b1;
                end
                MODE_ASCII: begin
                    if (n_chars == 0) begin
                        saw_colon = (b.rx_byte == ASCII_START);
                    end else begin
                        nib_ok = hex_nibble(b.rx_byte, nib);
                        if (n_chars % 2 == 1) begin
                            hi_nib = nib;
                            hi_bad = !nib_ok;
                        end else begin
                            pair = {hi_nib, nib};
                            if (pair_held) begin
                                if (saw_colon) begin
                                    r.data_byte  = pair_byte;
                                    r.data_valid = 1'b1;
                                end
                                if (pair_bad) begin
                                    bad_seen = 1'b1;
                                end
                            end
                            lrc_prev = lrc_acc;
                            lrc_acc  = lrc_acc + pair;
                            if (n_chars == 2) begin
                                addr_byte = pair;
                            end
                            pair_byte = pair;
                            pair_bad  = hi_bad || !nib_ok;
                            pair_held = 1'b1;
                        end
                    end
                end
                MODE_TCP: begin
                    if (n_chars == TCP_HEADER_LEN - 1) begin
                        addr_byte = b.rx_byte;
                    end
                    r.data_byte  = b.rx_byte;
                    r.data_valid = 1'b1;
                end
                default: begin
                end
            endcase
            n_chars++;
        end
        if (b.last_byte) begin
            n = n_chars;
            ok = 1'b0;
            len = 0;
            r.frame_done = 1'b1;
            if (!too_long && n >= 3) begin
                case (cur_mode)
                    MODE_RTU: begin
                        ok  = (crc_acc == 16'h0000);
                        len = n - 3;
                    end
                    MODE_ASCII: begin
                        summed = (n - 3) >> 1;
                        ok = saw_colon && !bad_seen && summed >= 2 && lrc_prev == 8'h00;
                        if (ok) begin
                            len = summed - 2;
                        end
                    end
                    MODE_TCP: begin
                        ok  = 1'b1;
                        len = (n >= TCP_HEADER_LEN) ? n - TCP_HEADER_LEN : 0;
                    end
                    default: begin
                    end
                endcase
            end
            if (ok) begin
                r.frame_ok     = 1'b1;
                r.node_address = addr_byte;
                r.pdu_length   = (len > 511) ? 9'd511 : 9'(len);
            end
            clear_frame_state();
        end
        return r;
    endfunction

    function automatic void build_frame(t_frame_mode m, int data_len);
        logic [15:0] crc;
        logic [7:0]  sum;
        logic [7:0]  b;
        int          pos;
        frame_chars.delete();
        case (m)
            MODE_RTU: begin
                crc = CRC_INIT;
                for (int k = 0; k <= data_len; k++) begin
                    b = 8'($urandom);
                    frame_chars.push_back(b);
                    crc = crc16_byte(crc, b);
                end
                frame_chars.push_back(crc[7:0]);
                frame_chars.push_back(crc[15:8]);
                if ($urandom_range(0, 5) == 0) begin
                    pos = $urandom_range(0, frame_chars.size() - 1);
                    frame_chars[pos] = frame_chars[pos] ^ (8'h01 << $urandom_range(0, 7));
                end
            end
            MODE_ASCII: begin
                sum = 8'h00;
                frame_chars.push_back(ASCII_START);
                for (int k = 0; k <= data_len + 1; k++) begin
                    b = (k == data_len + 1) ? 8'h00 - sum : 8'($urandom);
                    sum = sum + b;
                    frame_chars.push_back(to_hex_char(b[7:4]));
                    frame_chars.push_back(to_hex_char(b[3:0]));
                end
                frame_chars.push_back(CH_CR);
                frame_chars.push_back(CH_LF);
                case ($urandom_range(0, 11))
                    0: frame_chars[0] = 8'($urandom);
                    1: frame_chars[$urandom_range(1, frame_chars.size() - 3)] = 8'($urandom);
                    2: frame_chars[frame_chars.size() - 3] = frame_chars[frame_chars.size() - 3] ^ 8'h01;
                    3: frame_chars.pop_back();
                    4: begin
                        pos = $urandom_range(1, 6);
                        while (frame_chars.size() > pos) begin
                            frame_chars.pop_back();
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
                for (int k = 0; k <= data_len; k++) begin
                    frame_chars.push_back(8'($urandom));
                end
            end
        endcase
    endfunction

    task automatic push_char(input t_rx_beat b, input bit typed = 1'b0,
                             input t_rx_result want = '0);
        int         gap;
        t_rx_result guess;
        gap = idle_gap(send_idle);
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        do @(posedge clk); while (in_stall);
        accepted_chars++;
        guess = frame_check_step(b);
        pending_results.push_back(typed ? want : guess);
    endtask

    task automatic send_frame(input bit partial);
        int n;
        n = partial ? $urandom_range(1, frame_chars.size()) : frame_chars.size();
        for (int i = 0; i < n; i++) begin
            push_char({frame_chars[i], !partial && i == n - 1});
        end
    endtask

    task automatic write_mode(input t_frame_mode m);
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge clk);
        end
        repeat (4) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        cur_mode = m;
        clear_frame_state();
    endtask

    task automatic check_field(input string name, input int unsigned want_v,
                               input int unsigned got_v);
        if (want_v != got_v) begin
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want_v, got_v);
            mismatch_count++;
        end
    endtask

    always @(posedge clk) begin : result_check
        t_rx_result want;
        if (rst_n && out_valid && !out_stall) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $display("%0t: result beat 0x%0h expected none, got one", $time, out_data);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("data_byte", want.data_byte, out_data.data_byte);
                check_field("data_valid", want.data_valid, out_data.data_valid);
                check_field("frame_done", want.frame_done, out_data.frame_done);
                check_field("frame_ok", want.frame_ok, out_data.frame_ok);
                check_field("node_address", want.node_address, out_data.node_address);
                check_field("pdu_length", want.pdu_length, out_data.pdu_length);
            end
        end
    end

    initial begin : receiver
        int hold;
        bit held_off;
        hold = 0;
        held_off = 1'b0;
        forever begin
            @(negedge clk);
            if (!held_off && results_seen >= 60) begin
                held_off = 1'b1;
                hold = HOLD_OFF_CYCLES;
            end
            if (hold > 0) begin
                out_stall <= 1'b1;
                hold--;
            end else begin
                out_stall <= 1'b0;
                hold = idle_gap(recv_idle);
            end
        end
    end

    initial begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : stimulus
        t_frame_mode m;
        int          phase;
        int unsigned rand_stop;
        int unsigned phase_end;
        int          r;
        cur_mode = MODE_RTU;
        clear_frame_state();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < $size(DIRECTED); i++) begin
            if (DIRECTED[i].mode != cur_mode) begin
                write_mode(DIRECTED[i].mode);
            end
            push_char(DIRECTED[i].beat, DIRECTED[i].typed, DIRECTED[i].want);
        end

        phase = 0;
        rand_stop = accepted_chars + 430;
        while (accepted_chars < rand_stop) begin
            if (phase < 4) begin
                m = t_frame_mode'(phase);
            end else begin
                r = $urandom_range(0, 9);
                m = (r < 4) ? MODE_RTU : (r < 8) ? MODE_ASCII : (r < 9) ? MODE_TCP : MODE_FAIL;
            end
            write_mode(m);
            send_idle = ($urandom_range(0, 3) != 0);
            recv_idle = ($urandom_range(0, 3) != 0);
            phase_end = accepted_chars + $urandom_range(30, 90);
            while (accepted_chars < phase_end) begin
                build_frame(m, $urandom_range(0, 10));
                send_frame(1'b0);
            end
            if ($urandom_range(0, 2) == 0) begin
                build_frame(m, 4);
                send_frame(1'b1);
            end
            phase++;
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
